[rtl/bcpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcpa_pkg: shared types and codes of the contiguous page allocator
// Command and status codes, the request and response beat layouts and the
// result of the byte-wide run scanner.
// ----------------------------------------------------------------------------
package bcpa_pkg;

	// Field widths of the request and response beats.
	localparam int CMD_W   = 2;
	localparam int CNT_W   = 12;
	localparam int BASE_W  = 9;
	localparam int STAT_W  = 3;
	localparam int START_W = 8;

	// Page arithmetic width: holds base plus count and any pool size up to 4096.
	localparam int PG_XW = 14;

	// Pages examined per scan step (one bitmap byte).
	localparam int SCAN_W = 8;
	localparam int POS_W  = 3;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_COUNT = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_RUN    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd3;
	localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CNT_W-1:0]  page_count;
		logic [BASE_W-1:0] base_page;
		logic              base_present;
	} bcpa_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [START_W-1:0] start_page;
		logic               is_tracked;
	} bcpa_rsp_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] run;
	} bcpa_scan_t;

endpackage
`default_nettype wire

[rtl/bcpa_chan_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcpa_chan_if: valid/ready channel
// Carries one payload of type T per beat; a beat moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface bcpa_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/bcpa_run_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcpa_run_scan: first-fit run search over one bitmap byte
// Extends the running count of free pages across eight pages and reports
// the first page at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module bcpa_run_scan (
	input  wire logic [bcpa_pkg::SCAN_W-1:0] free_bits,
	input  wire logic [bcpa_pkg::CNT_W-1:0]  run_in,
	input  wire logic [bcpa_pkg::CNT_W-1:0]  count,
	output bcpa_pkg::bcpa_scan_t              res
);

	always_comb begin
		logic [bcpa_pkg::CNT_W-1:0] run;
		logic                        found;
		logic [bcpa_pkg::POS_W-1:0] pos;
		run   = run_in;
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < bcpa_pkg::SCAN_W; i++) begin
			if (!found) begin
				if (free_bits[i]) begin
					run = run + bcpa_pkg::CNT_W'(1);
					if (run == count) begin
						found = 1'b1;
						pos   = bcpa_pkg::POS_W'(i);
					end
				end else begin
					run = '0;
				end
			end
		end
		res.found = found;
		res.pos   = pos;
		res.run   = run;
	end

endmodule
`default_nettype wire

[rtl/bitmap_contiguous_page_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_contiguous_page_allocator: first-fit contiguous page allocator
// One bit per page marks occupancy; a slot table tracks granted run bases.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel (cmd, page_count, base_page,
// base_present) and each produces exactly one beat on the rsp channel
// (status, start_page, is_tracked). Commands are allocate, free and query.
// The block handles one request at a time; req.ready is high only while
// the sequencer is idle.
// Sequencing: a rejected or ignored request goes from idle straight to the
// finish state, which loads the rsp register.
// A query searches the slot table, which sits in a memory with one read
// port, one slot per cycle. An allocate scans the bitmap one byte per
// cycle, then searches for a free slot, then marks the run with a
// read-modify-write, a read state and a write state per bitmap byte it
// covers. A free searches the slots and then clears its pages the same way.
// Reset: after arst_n is released the bitmap memory is swept to zero, one
// byte per cycle, before the first request is accepted.
// Stalls: the result sits in an output register; the next request is
// accepted while it waits, and is held at its end until rsp drains.
// ----------------------------------------------------------------------------
module bitmap_contiguous_page_allocator #(
	parameter int POOL_PAGES  = 256,
	parameter int TRACK_SLOTS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bcpa_chan_if.sink   req,
	bcpa_chan_if.source rsp
);

	// Bitmap geometry: one byte of the memory holds eight pages.
	localparam int NWD = (POOL_PAGES + bcpa_pkg::SCAN_W - 1) / bcpa_pkg::SCAN_W;
	localparam int AW  = (NWD > 1) ? $clog2(NWD) : 1;
	localparam int PW  = $clog2(POOL_PAGES);
	localparam int SW  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
	localparam int XW  = bcpa_pkg::PG_XW;

	localparam logic [AW-1:0] WORD_LAST = AW'(NWD - 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(TRACK_SLOTS - 1);
	localparam logic [XW-1:0] POOL_X    = XW'(POOL_PAGES);

	// Sequencer states.
	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SLOT   = 3'd3;
	localparam logic [2:0] S_RMW_RD = 3'd4;
	localparam logic [2:0] S_RMW_WR = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0]                 state_q;
	bcpa_pkg::bcpa_req_t        req_q;
	bcpa_pkg::bcpa_rsp_t        res_q;
	bcpa_pkg::bcpa_rsp_t        rsp_q;
	logic                       rsp_valid_q;
	logic [AW-1:0]              clr_q;
	logic [AW-1:0]              wp_q;
	logic [bcpa_pkg::CNT_W-1:0] run_q;
	logic [XW-1:0]              start_q;
	logic [SW-1:0]              sp_q;
	logic [AW-1:0]              rw_q;
	logic [AW-1:0]              rlast_q;
	logic [XW-1:0]              rlo_q;
	logic [XW-1:0]              rhi_q;
	logic                       rset_q;
	logic [TRACK_SLOTS-1:0]     in_use_q;

	// Bitmap memory, one byte per word, and the slot base table.
	logic [bcpa_pkg::SCAN_W-1:0] page_mem_q [NWD];
	logic [bcpa_pkg::SCAN_W-1:0] pg_rd_s1;
	logic [PW-1:0]               slot_base_q [TRACK_SLOTS];
	logic [PW-1:0]               slot_rd_s1;

	logic [AW-1:0]               pg_ra;
	logic                        pg_we;
	logic [AW-1:0]               pg_wa;
	logic [bcpa_pkg::SCAN_W-1:0] pg_wd;
	logic [SW-1:0]               slot_ra;
	logic                        slot_we;

	logic [bcpa_pkg::SCAN_W-1:0] scan_free;
	logic [bcpa_pkg::SCAN_W-1:0] rmw_mask;
	bcpa_pkg::bcpa_scan_t        scan_res;
	logic [XW-1:0]               found_start;
	logic                        slot_hit;
	logic                        is_alloc;
	logic [XW-1:0]               rng_lo;
	logic [XW-1:0]               rng_sum;
	logic [XW-1:0]               rng_hi;
	logic [XW-1:0]               rng_hi_m1;
	logic                        rsp_free;

	assign is_alloc = (req_q.cmd == bcpa_pkg::CMD_ALLOC);
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// Free pages of the byte under scan; pages past the pool end count as busy.
	always_comb begin
		logic [AW+2:0] pidx;
		for (int i = 0; i < bcpa_pkg::SCAN_W; i++) begin
			pidx         = {wp_q, bcpa_pkg::POS_W'(i)};
			scan_free[i] = !pg_rd_s1[i] && (XW'(pidx) < POOL_X);
		end
	end

	bcpa_run_scan u_run_scan (
		.free_bits (scan_free),
		.run_in    (run_q),
		.count     (req_q.page_count),
		.res       (scan_res)
	);

	// The run ends at the found page, so its first page is end + 1 - count.
	assign found_start = XW'({wp_q, scan_res.pos}) + XW'(1) - XW'(req_q.page_count);

	// Allocation wants a free slot; free and query want a used slot holding base.
	assign slot_hit = is_alloc ? !in_use_q[sp_q]
		: (in_use_q[sp_q] && (XW'(slot_rd_s1) == XW'(req_q.base_page)));

	// Page range touched by the read-modify-write pass; a free is clipped.
	always_comb begin
		rng_lo    = is_alloc ? start_q : XW'(req_q.base_page);
		rng_sum   = rng_lo + XW'(req_q.page_count);
		rng_hi    = (!is_alloc && (rng_sum > POOL_X)) ? POOL_X : rng_sum;
		rng_hi_m1 = rng_hi - XW'(1);
	end

	always_comb begin
		logic [AW+2:0] pidx;
		for (int i = 0; i < bcpa_pkg::SCAN_W; i++) begin
			pidx        = {rw_q, bcpa_pkg::POS_W'(i)};
			rmw_mask[i] = (XW'(pidx) >= rlo_q) && (XW'(pidx) < rhi_q);
		end
	end

	// Memory addressing. Idle states read address zero so that a scan can
	// start with byte zero or slot zero already on the read port.
	always_comb begin
		pg_ra   = '0;
		slot_ra = '0;
		pg_we   = 1'b0;
		pg_wa   = rw_q;
		pg_wd   = rset_q ? (pg_rd_s1 | rmw_mask) : (pg_rd_s1 & ~rmw_mask);
		case (state_q)
			S_CLR: begin
				pg_we = 1'b1;
				pg_wa = clr_q;
				pg_wd = '0;
			end
			S_SCAN: begin
				pg_ra = (wp_q == WORD_LAST) ? '0 : wp_q + AW'(1);
			end
			S_SLOT: begin
				slot_ra = (sp_q == SLOT_LAST) ? '0 : sp_q + SW'(1);
			end
			S_RMW_RD: begin
				pg_ra = rw_q;
			end
			S_RMW_WR: begin
				pg_we = 1'b1;
			end
			default: begin
				pg_ra = '0;
			end
		endcase
	end

	assign slot_we = (state_q == S_SLOT) && is_alloc && slot_hit;

	always_ff @(posedge clk) begin
		if (pg_we) begin
			page_mem_q[pg_wa] <= pg_wd;
		end
		pg_rd_s1 <= page_mem_q[pg_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_base_q[sp_q] <= start_q[PW-1:0];
		end
		slot_rd_s1 <= slot_base_q[slot_ra];
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			in_use_q    <= '0;
		end else begin
			// The output register empties on a taken beat unless a new result loads.
			if (rsp_valid_q && rsp.ready && !((state_q == S_FIN) && rsp_free)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == WORD_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						req_q            <= req.data;
						res_q.start_page <= '0;
						res_q.is_tracked <= 1'b0;
						wp_q             <= '0;
						run_q            <= '0;
						sp_q             <= '0;
						case (req.data.cmd)
							bcpa_pkg::CMD_ALLOC: begin
								if ((req.data.page_count == '0)
										|| (XW'(req.data.page_count) > POOL_X)) begin
									res_q.status <= bcpa_pkg::ST_BAD_COUNT;
									state_q      <= S_FIN;
								end else begin
									res_q.status <= bcpa_pkg::ST_OK;
									state_q      <= S_SCAN;
								end
							end
							bcpa_pkg::CMD_FREE: begin
								if (!req.data.base_present || (req.data.page_count == '0)
										|| (XW'(req.data.base_page) >= POOL_X)) begin
									res_q.status <= bcpa_pkg::ST_IGNORED;
									state_q      <= S_FIN;
								end else begin
									res_q.status <= bcpa_pkg::ST_OK;
									state_q      <= S_SLOT;
								end
							end
							bcpa_pkg::CMD_QUERY: begin
								// A null base is never tracked.
								res_q.status <= bcpa_pkg::ST_OK;
								state_q      <= req.data.base_present ? S_SLOT : S_FIN;
							end
							default: begin
								res_q.status <= bcpa_pkg::ST_IGNORED;
								state_q      <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_res.found) begin
						start_q <= found_start;
						state_q <= S_SLOT;
					end else if (wp_q == WORD_LAST) begin
						res_q.status <= bcpa_pkg::ST_NO_RUN;
						state_q      <= S_FIN;
					end else begin
						wp_q  <= wp_q + AW'(1);
						run_q <= scan_res.run;
					end
				end
				S_SLOT: begin
					if (slot_hit || (sp_q == SLOT_LAST)) begin
						// Range for the bitmap update, used by allocate and free.
						rw_q    <= rng_lo[AW+2:3];
						rlast_q <= rng_hi_m1[AW+2:3];
						rlo_q   <= rng_lo;
						rhi_q   <= rng_hi;
						rset_q  <= is_alloc;
						case (req_q.cmd)
							bcpa_pkg::CMD_ALLOC: begin
								if (slot_hit) begin
									in_use_q[sp_q]   <= 1'b1;
									res_q.start_page <= start_q[bcpa_pkg::START_W-1:0];
									state_q          <= S_RMW_RD;
								end else begin
									res_q.status <= bcpa_pkg::ST_NO_SLOT;
									state_q      <= S_FIN;
								end
							end
							bcpa_pkg::CMD_FREE: begin
								// Pages are cleared whether or not the base is tracked.
								if (slot_hit) begin
									in_use_q[sp_q] <= 1'b0;
								end
								state_q <= S_RMW_RD;
							end
							default: begin
								res_q.is_tracked <= slot_hit;
								state_q          <= S_FIN;
							end
						endcase
					end else begin
						sp_q <= sp_q + SW'(1);
					end
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				S_RMW_WR: begin
					if (rw_q == rlast_q) begin
						state_q <= S_FIN;
					end else begin
						rw_q    <= rw_q + AW'(1);
						state_q <= S_RMW_RD;
					end
				end
				S_FIN: begin
					if (rsp_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[tb/bcpa_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcpa_checker: response scoreboard for the contiguous page allocator
// Runs every accepted request through a behavioral copy of the page map and
// the slot table. It queues the response that copy gives and compares each
// response beat of the block with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module bcpa_checker
	import bcpa_pkg::*;
#(
	parameter int POOL_PAGES  = 256,
	parameter int TRACK_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  bcpa_req_t   req_beat,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  bcpa_rsp_t   rsp_beat,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	logic               page_busy [POOL_PAGES];
	logic               slot_used [TRACK_SLOTS];
	logic [START_W-1:0] slot_base [TRACK_SLOTS];
	bcpa_rsp_t          rsp_expect_q [$];
	bcpa_rsp_t          want;
	int                 i;

	// Lowest used slot whose base equals the given page, or -1.
	function automatic int holder_slot(logic [BASE_W-1:0] base);
		int s;
		int hit;
		hit = -1;
		for (s = 0; s < TRACK_SLOTS && hit < 0; s++)
			if (slot_used[s] && BASE_W'(slot_base[s]) == base)
				hit = s;
		return hit;
	endfunction

	// Applies one request to the page map and slot table and returns the
	// response the block owes for it.
	function automatic bcpa_rsp_t pool_apply(bcpa_req_t r);
		bcpa_rsp_t res;
		int cnt;
		int run_len;
		int first;
		int last;
		int s;
		int p;
		res = '0;
		res.status = ST_OK;
		cnt = int'(r.page_count);
		case (r.cmd)
			CMD_ALLOC: begin
				if (cnt == 0 || cnt > POOL_PAGES) begin
					res.status = ST_BAD_COUNT;
				end else begin
					run_len = 0;
					first = -1;
					for (p = 0; p < POOL_PAGES && first < 0; p++) begin
						if (page_busy[p]) begin
							run_len = 0;
						end else begin
							run_len++;
							if (run_len == cnt)
								first = p - cnt + 1;
						end
					end
					if (first < 0) begin
						res.status = ST_NO_RUN;
					end else begin
						s = -1;
						for (p = 0; p < TRACK_SLOTS && s < 0; p++)
							if (!slot_used[p])
								s = p;
						if (s < 0) begin
							res.status = ST_NO_SLOT;
						end else begin
							for (p = first; p < first + cnt; p++)
								page_busy[p] = 1'b1;
							slot_used[s] = 1'b1;
							slot_base[s] = START_W'(first);
							res.start_page = START_W'(first);
						end
					end
				end
			end
			CMD_FREE: begin
				if (!r.base_present || cnt == 0 || int'(r.base_page) >= POOL_PAGES) begin
					res.status = ST_IGNORED;
				end else begin
					last = int'(r.base_page) + cnt;
					if (last > POOL_PAGES)
						last = POOL_PAGES;
					for (p = int'(r.base_page); p < last; p++)
						page_busy[p] = 1'b0;
					s = holder_slot(r.base_page);
					if (s >= 0)
						slot_used[s] = 1'b0;
				end
			end
			CMD_QUERY: begin
				res.is_tracked = r.base_present && holder_slot(r.base_page) >= 0;
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < POOL_PAGES; i++)
				page_busy[i] = 1'b0;
			for (i = 0; i < TRACK_SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_base[i] = '0;
			end
			rsp_expect_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_expect_q.size() == 0) begin
					$display("%0t: unexpected beat: status %0d start %0d tracked %0d",
						$time, rsp_beat.status, rsp_beat.start_page, rsp_beat.is_tracked);
					mismatches++;
				end else begin
					want = rsp_expect_q.pop_front();
					if (rsp_beat.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp_beat.status);
						mismatches++;
					end
					if (rsp_beat.start_page !== want.start_page) begin
						$display("%0t: start_page expected %0d, got %0d",
							$time, want.start_page, rsp_beat.start_page);
						mismatches++;
					end
					if (rsp_beat.is_tracked !== want.is_tracked) begin
						$display("%0t: is_tracked expected %0d, got %0d",
							$time, want.is_tracked, rsp_beat.is_tracked);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready)
				rsp_expect_q.push_back(pool_apply(req_beat));
			outstanding = rsp_expect_q.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the contiguous page allocator
// Drives request beats into the allocator and takes its response beats with
// random stalls; a scoreboard beside the block predicts and checks every
// response. A short directed run hits the corner cases first, then random
// traffic that mostly allocates, frees what was granted and queries it.
// ----------------------------------------------------------------------------
module tb;
	import bcpa_pkg::*;

	localparam int POOL_PAGES  = 256;
	localparam int TRACK_SLOTS = 32;

	// The command code the block does not define; it must be ignored.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Number of request beats after which the random traffic stops.
	localparam int ITEM_TARGET = 850;

	// Length of the one long receiver hold-off, in clock cycles. It is far
	// longer than any single request takes, so the block must back up.
	localparam int RSP_HOLD_CYCLES = 200;

	// Cycles to wait once nothing is expected any more; covers the slowest
	// allocate (bitmap scan, slot search and marking) with margin.
	localparam int SETTLE_CYCLES = 150;

	// A run that the block granted and the stimulus may give back later.
	typedef struct {
		logic [START_W-1:0] first;
		logic [CNT_W-1:0]   len;
	} grant_t;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned items_sent;
	bit          no_idle;
	bit          hold_rsp;

	bcpa_req_t   issued_q [$];
	bcpa_req_t   issued_head;
	grant_t      live_runs [$];

	bcpa_chan_if #(.T(bcpa_req_t)) req_if ();
	bcpa_chan_if #(.T(bcpa_rsp_t)) rsp_if ();

	bitmap_contiguous_page_allocator #(
		.POOL_PAGES  (POOL_PAGES),
		.TRACK_SLOTS (TRACK_SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	bcpa_checker #(
		.POOL_PAGES  (POOL_PAGES),
		.TRACK_SLOTS (TRACK_SLOTS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_if.valid),
		.req_ready   (req_if.ready),
		.req_beat    (req_if.data),
		.rsp_valid   (rsp_if.valid),
		.rsp_ready   (rsp_if.ready),
		.rsp_beat    (rsp_if.data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Idle length: mostly short, now and then a long pause.
	function automatic int idle_len();
		if ($urandom_range(99, 0) < 85)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Allocation size: mostly small runs, so a single scan stays short, with
	// a few big ones that cross many bitmap bytes or cannot fit at all.
	function automatic logic [CNT_W-1:0] alloc_count();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 60)
			return CNT_W'($urandom_range(8, 1));
		if (roll < 85)
			return CNT_W'($urandom_range(40, 9));
		if (roll < 95)
			return CNT_W'($urandom_range(128, 41));
		return CNT_W'($urandom_range(POOL_PAGES, 129));
	endfunction

	// A request with every field random, including the unused command code,
	// oversized counts and bases outside the pool.
	function automatic bcpa_req_t noise_req();
		bcpa_req_t r;
		r.cmd = CMD_W'($urandom_range(3, 0));
		if ($urandom_range(1, 0) == 1)
			r.page_count = CNT_W'($urandom_range(4095, 0));
		else
			r.page_count = CNT_W'($urandom_range(300, 0));
		r.base_page    = BASE_W'($urandom_range(511, 0));
		r.base_present = 1'($urandom_range(1, 0));
		return r;
	endfunction

	// Everyday traffic: allocate, give back a granted run (now and then with
	// a count that runs past the pool end), query a live base or a random
	// one, and a little noise.
	function automatic bcpa_req_t mixed_req();
		bcpa_req_t r;
		grant_t    g;
		int        roll;
		int        k;
		r = noise_req();
		roll = $urandom_range(99, 0);
		if (roll >= 40 && roll < 72 && live_runs.size() > 0) begin
			k = $urandom_range(live_runs.size() - 1, 0);
			g = live_runs[k];
			live_runs.delete(k);
			r.cmd = CMD_FREE;
			r.base_page = BASE_W'(g.first);
			r.base_present = 1'b1;
			r.page_count = g.len;
			if ($urandom_range(9, 0) == 0)
				r.page_count = CNT_W'($urandom_range(4095, int'(g.len)));
		end else if (roll < 72) begin
			r.cmd = CMD_ALLOC;
			r.page_count = alloc_count();
		end else if (roll < 92) begin
			r.cmd = CMD_QUERY;
			if (live_runs.size() > 0 && $urandom_range(9, 0) < 6) begin
				k = $urandom_range(live_runs.size() - 1, 0);
				r.base_page = BASE_W'(live_runs[k].first);
				r.base_present = 1'b1;
			end
		end
		return r;
	endfunction

	// Offers one beat and returns at the falling edge after it was taken.
	// The valid line stays high into the next beat unless a gap is drawn,
	// so back-to-back beats never lower and raise it in one time step.
	task automatic send_req(input bcpa_req_t r);
		int gap;
		gap = (no_idle || $urandom_range(99, 0) < 55) ? 0 : idle_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_fields(input logic [CMD_W-1:0] c, input int cnt, input int base,
			input logic present);
		bcpa_req_t r;
		r.cmd          = c;
		r.page_count   = CNT_W'(cnt);
		r.base_page    = BASE_W'(base);
		r.base_present = present;
		send_req(r);
	endtask

	// Stops offering and waits until every response has come back.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// A burst of small allocations, more than there are tracking slots, so
	// the slot table runs out and the block reports that no slot is free.
	task automatic fill_slots();
		bcpa_req_t r;
		repeat (TRACK_SLOTS + 8) begin
			r = noise_req();
			r.cmd = CMD_ALLOC;
			r.page_count = CNT_W'($urandom_range(4, 1));
			send_req(r);
		end
	endtask

	// Gives back every run the stimulus still knows about.
	task automatic free_all_runs();
		grant_t g;
		while (live_runs.size() > 0) begin
			g = live_runs.pop_front();
			send_fields(CMD_FREE, int'(g.len), int'(g.first), 1'b1);
		end
	endtask

	// Pairs every response with the request that caused it, so that the
	// stimulus learns which runs were granted and can free them later.
	always @(posedge clk) begin
		if (req_if.valid && req_if.ready)
			issued_q.push_back(req_if.data);
		if (rsp_if.valid && rsp_if.ready && issued_q.size() > 0) begin
			issued_head = issued_q.pop_front();
			if (issued_head.cmd == CMD_ALLOC && rsp_if.data.status == ST_OK)
				live_runs.push_back('{first: rsp_if.data.start_page,
					len: issued_head.page_count});
		end
	end

	// Response side. Ready drops for random stretches, except while a phase
	// asks for steady traffic. When the stimulus requests a hold-off, ready
	// stays low for a long stretch counted here, while requests keep coming.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_if.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
				if (!no_idle && $urandom_range(99, 0) < 25)
					stall_left = idle_len();
			end
		end
	end

	// Main sequence.
	initial begin
		req_if.valid = 1'b0;
		req_if.data  = '0;
		no_idle      = 1'b0;
		hold_rsp     = 1'b0;
		items_sent   = 0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. The pool starts empty, so each response is known:
		// rejected counts (zero, one past the pool, all count bits set), the
		// whole pool in one run, no run left, queries with a null base and a
		// base outside the pool, every way a free is ignored, the unused
		// command, a free of a base that no slot holds, a first-fit hole,
		// and frees that run past the end of the pool.
		send_fields(CMD_ALLOC,     0,   0, 1'b1);
		send_fields(CMD_ALLOC,   257,   0, 1'b1);
		send_fields(CMD_ALLOC,  4095, 511, 1'b0);
		send_fields(CMD_ALLOC,   256,   0, 1'b1);
		send_fields(CMD_ALLOC,     1,   0, 1'b1);
		send_fields(CMD_QUERY,     0,   0, 1'b1);
		send_fields(CMD_QUERY,     0,   0, 1'b0);
		send_fields(CMD_QUERY,  4095, 511, 1'b1);
		send_fields(CMD_FREE,      0,   0, 1'b1);
		send_fields(CMD_FREE,    256,   0, 1'b0);
		send_fields(CMD_FREE,      1, 256, 1'b1);
		send_fields(CMD_UNUSED, 4095, 511, 1'b1);
		send_fields(CMD_FREE,    256,   0, 1'b1);
		send_fields(CMD_QUERY,     1,   0, 1'b1);
		send_fields(CMD_ALLOC,    10,   0, 1'b0);
		send_fields(CMD_ALLOC,    20,   0, 1'b0);
		send_fields(CMD_FREE,      2,   3, 1'b1);
		send_fields(CMD_ALLOC,     2,   0, 1'b0);
		send_fields(CMD_FREE,   4095, 250, 1'b1);
		send_fields(CMD_ALLOC,   200,   0, 1'b0);
		send_fields(CMD_ALLOC,    30,   0, 1'b0);
		send_fields(CMD_FREE,     20,  10, 1'b1);
		send_fields(CMD_QUERY,     0,  30, 1'b1);
		send_fields(CMD_FREE,   4000,  30, 1'b1);
		send_fields(CMD_QUERY,     0,  30, 1'b1);
		wait_drained();

		repeat (150) send_req(mixed_req());

		// Slot exhaustion under back-pressure: the receiver holds off while
		// the sender keeps pushing, so the block fills and stalls its input.
		no_idle = 1'b1;
		hold_rsp = 1'b1;
		fill_slots();
		no_idle = 1'b0;
		wait_drained();
		free_all_runs();

		// A stretch with no idling on either side.
		no_idle = 1'b1;
		repeat (100) send_req(mixed_req());
		no_idle = 1'b0;

		repeat (200) send_req(mixed_req());
		wait_drained();
		fill_slots();
		wait_drained();
		free_all_runs();

		while (items_sent < ITEM_TARGET)
			send_req(mixed_req());

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
